/* design/utf16_unit_to_utf8_encoder_unit_macros.svh */
// Assertion macros shared by the encoder RTL.
`ifndef UTF16_UNIT_TO_UTF8_ENCODER_UNIT_MACROS_SVH
`define UTF16_UNIT_TO_UTF8_ENCODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked on every rising clk edge outside reset.
`define U2U8_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("u2u8 assertion failed");
// Next-cycle implication.
`define U2U8_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("u2u8 assertion failed");
`else
`define U2U8_ASSERT_IMP(label, clk, rst, cond, prop)
`define U2U8_ASSERT_NXT(label, clk, rst, cond, prop)
`endif

`endif

/* design/u2u8_pkg.sv */
package u2u8_pkg;

  // Configuration register indexes
  localparam logic REG_BYTE_BUDGET = 1'b0;
  localparam logic REG_COUNT_ONLY  = 1'b1;

  localparam logic [15:0] BUDGET_RESET = 16'hffff;

  // One character's worth of result beats, handed from encoder to serializer.
  typedef struct packed {
    logic [1:0]  cnt;         // beats left, 1..3
    logic [7:0]  b0;          // byte of the next beat
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        byte_valid;
    logic        done;
    logic [15:0] total;       // total_written of the next beat
  } rec_t;

endpackage

/* design/u2u8_encode.sv */
module u2u8_encode (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               fire,
  input  logic [15:0]        code_unit,
  input  logic               start_of_string,
  output logic               rec_valid,
  output u2u8_pkg::rec_t     rec
);

  logic [15:0] byte_budget;
  logic        count_only;
  logic [15:0] bytes_written;
  logic [15:0] bytes_written_next;
  logic        stopped;
  logic        stopped_next;

  logic [15:0] bw;
  logic        stp;
  logic [1:0]  nbytes;
  logic [16:0] sum;
  logic [7:0]  e0;
  logic [7:0]  e1;
  logic [7:0]  e2;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget <= u2u8_pkg::BUDGET_RESET;
      count_only  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        u2u8_pkg::REG_BYTE_BUDGET: byte_budget <= cfg_data;
        u2u8_pkg::REG_COUNT_ONLY:  count_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // start of string clears the running state before this unit
    bw  = start_of_string ? 16'd0 : bytes_written;
    stp = start_of_string ? 1'b0 : stopped;

    if (code_unit <= 16'h007f) begin
      nbytes = 2'd1;
      e0 = {1'b0, code_unit[6:0]};
      e1 = 8'h00;
      e2 = 8'h00;
    end else if (code_unit <= 16'h07ff) begin
      nbytes = 2'd2;
      e0 = {3'b110, code_unit[10:6]};
      e1 = {2'b10, code_unit[5:0]};
      e2 = 8'h00;
    end else begin
      nbytes = 2'd3;
      e0 = {4'b1110, code_unit[15:12]};
      e1 = {2'b10, code_unit[11:6]};
      e2 = {2'b10, code_unit[5:0]};
    end
    sum = {1'b0, bw} + {15'd0, nbytes};

    rec_valid          = 1'b0;
    rec                = '0;
    rec.cnt            = 2'd1;
    rec.total          = bw;
    rec.done           = 1'b1;
    bytes_written_next = bw;
    stopped_next       = stp;

    if (stp) begin
      rec_valid = 1'b0;
    end else if (code_unit == 16'd0 || bw >= byte_budget ||
                 sum > {1'b0, byte_budget}) begin
      // terminator, budget used up, or character does not fit
      rec_valid    = 1'b1;
      stopped_next = 1'b1;
    end else if (count_only) begin
      rec_valid          = 1'b1;
      rec.done           = 1'b0;
      rec.total          = sum[15:0];
      bytes_written_next = sum[15:0];
    end else begin
      rec_valid          = 1'b1;
      rec.done           = 1'b0;
      rec.byte_valid     = 1'b1;
      rec.cnt            = nbytes;
      rec.b0             = e0;
      rec.b1             = e1;
      rec.b2             = e2;
      rec.total          = bw + 16'd1;
      bytes_written_next = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= 16'd0;
      stopped       <= 1'b0;
    end else if (fire) begin
      bytes_written <= bytes_written_next;
      stopped       <= stopped_next;
    end
  end

endmodule

/* design/u2u8_serial.sv */
module u2u8_serial (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  u2u8_pkg::rec_t     rec_in,
  output logic               ready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               last,
  output logic               done_res,
  output logic [15:0]        total_written
);

  logic           rec_valid;
  u2u8_pkg::rec_t rec;
  logic           out_free;
  logic           move;
  logic           rec_end;

  assign out_free = !m_tvalid || m_tready;
  assign move     = rec_valid && out_free;
  assign rec_end  = move && (rec.cnt == 2'd1);
  assign ready    = !rec_valid || rec_end;

  // pending character beats
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (load) begin
      rec_valid <= 1'b1;
    end else if (rec_end) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end else if (move) begin
      rec.cnt   <= rec.cnt - 2'd1;
      rec.b0    <= rec.b1;
      rec.b1    <= rec.b2;
      rec.total <= rec.total + 16'd1;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte      <= rec.b0;
      byte_valid    <= rec.byte_valid;
      last          <= (rec.cnt == 2'd1);
      done_res      <= rec.done;
      total_written <= rec.total;
    end
  end

endmodule

/* design/utf16_unit_to_utf8_encoder_unit.sv */
// UTF-16 code unit to UTF-8 byte encoder with a per-string byte budget.
//
// Input stream (s_*): one 16-bit code unit per beat, s_tuser = start of string.
// Output stream (m_*): one result per beat; out_byte and total_written in
// m_tdata, byte_valid and done_res flags in m_tuser, m_tlast on the final
// result of each code unit. A zero unit or an exhausted budget gives a single
// done beat carrying the total; later units are dropped until start of string.
// Config channel (cfg_*): index 0 = byte_budget, 1 = count_only; always ready.
//
// The first result beat passes through the record register and then the
// output beat register. Throughput: one unit per cycle for ASCII, count-only
// and done results while m_tready is high; a two- or three-byte character
// holds s_tready low until its last byte moves to the byte-wide output register.
// Reset (rst, synchronous): budget 65535, count_only 0, count and stop cleared,
// output empty. When m_tready is low the output beat holds, the pending
// character waits in one record register, and s_tready drops once it is full.
`include "utf16_unit_to_utf8_encoder_unit_macros.svh"

module utf16_unit_to_utf8_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] code_unit
  input  logic        s_tuser,   // [0] start_of_string
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] total_written
  output logic [1:0]  m_tuser,   // [0] byte_valid, [1] done_res
  output logic        m_tlast
);

  logic           s_fire;
  logic           enc_valid;
  u2u8_pkg::rec_t enc_rec;
  logic [7:0]     out_byte;
  logic           byte_valid;
  logic           done_res;
  logic [15:0]    total_written;

  assign cfg_ready = 1'b1;
  assign s_fire    = s_tvalid && s_tready;

  // budget check and UTF-8 packing, state updated on every accepted beat
  u2u8_encode u_encode (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fire            (s_fire),
    .code_unit       (s_tdata),
    .start_of_string (s_tuser),
    .rec_valid       (enc_valid),
    .rec             (enc_rec)
  );

  // record register plus output beat register; splits a character into beats
  u2u8_serial u_serial (
    .clk           (clk),
    .rst           (rst),
    .load          (s_fire && enc_valid),
    .rec_in        (enc_rec),
    .ready         (s_tready),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (m_tlast),
    .done_res      (done_res),
    .total_written (total_written)
  );

  assign m_tdata = {total_written, out_byte};
  assign m_tuser = {done_res, byte_valid};

  // a done beat never carries a byte
  `U2U8_ASSERT_IMP(a_done_no_byte, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]))
  // count-only and done beats are single-beat results
  `U2U8_ASSERT_IMP(a_nobyte_last, clk, rst, m_tvalid && !m_tuser[0], m_tlast)
  // the rest of a character follows with no gap once a beat is taken
  `U2U8_ASSERT_NXT(a_char_cont, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid)
  // byte beats of one character count up by one
  `U2U8_ASSERT_NXT(a_total_step, clk, rst, m_tvalid && m_tready && !m_tlast,
                   m_tdata[23:8] == $past(m_tdata[23:8]) + 16'd1)

endmodule

/* dv/tb_utf16_unit_to_utf8_encoder_unit.sv */
`timescale 1ns / 100ps

module tb_utf16_unit_to_utf8_encoder_unit;

  localparam int DRAIN_CYCLES = 4;     // margin on top of the output path
  localparam int LONG_HOLD    = 300;   // receiver hold-off that fills the block
  localparam int HOLD_AT_UNIT = 150;   // accepted units before the long hold
  localparam int IDLE_LIMIT   = 3000;  // watchdog: cycles with no beat on any channel
  localparam int PHASES       = 10;
  localparam int UNITS_PER_PH = 40;    // minimum accepted units per phase, dropped ones included

  // One result beat, fields in the order of the byte/flag/total breakdown
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_flag;
    logic        done_res;
    logic [15:0] total_written;
  } beat_t;

  typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_t;

  // Directed stimulus row; typed rows carry their one expected beat (or none)
  typedef struct {
    row_kind_t   kind;
    logic        reg_index;
    logic [15:0] value;       // code unit or register data
    logic        sos;
    bit          typed;
    int          n_typed;
    beat_t       typed_beat;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [15:0] code_unit
  logic        s_tuser = 1'b0;  // [0] start_of_string
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // [7:0] out_byte, [23:8] total_written
  logic [1:0]  m_tuser;         // [0] byte_valid, [1] done_res
  logic        m_tlast;

  utf16_unit_to_utf8_encoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Encoder shadow: registers and per-string state as the block should hold them
  // ---------------------------------------------------------------------------
  logic [15:0] cur_budget     = u2u8_pkg::BUDGET_RESET;
  logic        cur_count_only = 1'b0;
  int          str_count      = 0;     // bytes counted in the current string
  bit          str_stopped    = 1'b0;  // string ended, units dropped until sos

  beat_t       pending_beats[$];       // expected beats, oldest first
  int          fail_count     = 0;
  int          units_accepted = 0;
  bit          long_hold_armed = 1'b0;
  bit          quiet_tail     = 1'b0;  // no idling on either side from here on
  int          idle_cycles    = 0;
  stim_row_t   directed_rows[$];

  function automatic beat_t done_beat(input logic [15:0] total);
    return {8'h00, 1'b0, 1'b1, 1'b1, total};
  endfunction

  function automatic beat_t char_beat(input logic [7:0] b, input logic [15:0] total);
    return {b, 1'b1, 1'b1, 1'b0, total};
  endfunction

  // Encodes one code unit against the shadow state; returns the number of beats
  // it causes. With keep clear only the state moves (the row supplies the beats).
  function automatic int encode_unit(input logic [15:0] cu, input logic sos, input bit keep);
    int          nb;
    int          k;
    logic [7:0]  enc [0:2];
    beat_t       b;
    if (sos) begin
      str_count   = 0;
      str_stopped = 1'b0;
    end
    if (str_stopped) return 0;
    // terminator, or budget already used up
    if (cu == 16'h0000 || str_count >= cur_budget) begin
      if (keep) pending_beats.push_back(done_beat(str_count[15:0]));
      str_stopped = 1'b1;
      return 1;
    end
    enc[1] = '0;
    enc[2] = '0;
    if (cu <= 16'h007f) begin
      nb     = 1;
      enc[0] = cu[7:0] & 8'h7f;
    end else if (cu <= 16'h07ff) begin
      nb     = 2;
      enc[0] = 8'hc0 | {3'b000, cu[10:6]};
      enc[1] = 8'h80 | {2'b00, cu[5:0]};
    end else begin
      nb     = 3;
      enc[0] = 8'he0 | {4'h0, cu[15:12]};
      enc[1] = 8'h80 | {2'b00, cu[11:6]};
      enc[2] = 8'h80 | {2'b00, cu[5:0]};
    end
    // character would not fit in what is left of the budget
    if (str_count + nb > cur_budget) begin
      if (keep) pending_beats.push_back(done_beat(str_count[15:0]));
      str_stopped = 1'b1;
      return 1;
    end
    if (cur_count_only) begin
      str_count += nb;
      b = {8'h00, 1'b0, 1'b1, 1'b0, str_count[15:0]};
      if (keep) pending_beats.push_back(b);
      return 1;
    end
    for (k = 0; k < nb; k++) begin
      str_count += 1;
      b = {enc[k], 1'b1, (k == nb - 1), 1'b0, str_count[15:0]};
      if (keep) pending_beats.push_back(b);
    end
    return nb;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a rising edge. Offers one unit, waits for the beat, then maybe
  // leaves a gap. Valid is left high when the next unit follows at once.
  task automatic send_unit(input logic [15:0] cu, input logic sos, input bit typed,
                           input int n_typed, input beat_t typed_beat, output int n_res);
    s_tvalid <= 1'b1;
    s_tdata  <= cu;
    s_tuser  <= sos;
    do @(posedge clk); while (!s_tready);
    n_res = encode_unit(cu, sos, !typed);
    if (typed && n_typed != 0) pending_beats.push_back(typed_beat);
    units_accepted++;
    if (units_accepted == HOLD_AT_UNIT) long_hold_armed = 1'b1;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Register write: only once the block has drained. Dropped units leave no
  // beat behind, so a few extra cycles cover one still in flight.
  task automatic write_reg(input logic idx, input logic [15:0] data);
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == u2u8_pkg::REG_BYTE_BUDGET) cur_budget = data;
    else cur_count_only = data[0];
    cfg_valid <= 1'b0;
  endtask

  // Mostly printable/BMP characters spread over the three encoding lengths
  function automatic logic [15:0] rand_unit();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'($urandom_range(16'h0001, 16'h007f));
      3, 4, 5: return 16'($urandom_range(16'h0080, 16'h07ff));
      6, 7, 8: return 16'($urandom_range(16'h0800, 16'hffff));
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  // One string: characters, usually a terminator, sometimes trailing junk
  // (dropped while stopped) or a restart in the middle.
  task automatic send_string(input logic first_sos, inout int counted);
    int   len;
    int   i;
    int   n;
    logic sos;
    len = $urandom_range(0, 12);
    for (i = 0; i < len; i++) begin
      sos = (i == 0) ? first_sos : ($urandom_range(0, 29) == 0);
      send_unit(rand_unit(), sos, 1'b0, 0, '0, n);
      counted++;
    end
    if ($urandom_range(0, 4) != 0) begin
      send_unit(16'h0000, (len == 0), 1'b0, 0, '0, n);
      counted++;
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_unit(rand_unit(), 1'b0, 1'b0, 0, '0, n);
        counted++;
      end
    end
  endtask

  task automatic add_unit(input logic [15:0] cu, input logic sos);
    directed_rows.push_back('{ROW_UNIT, 1'b0, cu, sos, 1'b0, 0, '0});
  endtask

  task automatic add_typed(input logic [15:0] cu, input logic sos, input int n,
                           input beat_t b);
    directed_rows.push_back('{ROW_UNIT, 1'b0, cu, sos, 1'b1, n, b});
  endtask

  task automatic add_cfg(input logic idx, input logic [15:0] data);
    directed_rows.push_back('{ROW_CFG, idx, data, 1'b0, 1'b0, 0, '0});
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          r;
    int          n;
    int          ph;
    int          counted;
    logic [15:0] budget;
    logic        co;
    logic [31:0] junk;

    // reset defaults: budget 65535, emit mode
    add_typed(16'h0041, 1'b1, 1, char_beat(8'h41, 16'd1));
    add_typed(16'h007f, 1'b0, 1, char_beat(8'h7f, 16'd2));
    add_unit(16'h0080, 1'b0);                 // smallest two-byte
    add_unit(16'h07ff, 1'b0);                 // largest two-byte
    add_unit(16'h0800, 1'b0);                 // smallest three-byte
    add_unit(16'hffff, 1'b0);                 // largest unit
    add_unit(16'hd800, 1'b0);                 // surrogate, plain three-byte
    add_typed(16'h0000, 1'b0, 1, done_beat(16'd15));
    add_typed(16'h0041, 1'b0, 0, '0);         // stopped: dropped
    add_typed(16'h0000, 1'b1, 1, done_beat(16'd0));
    // tight budget: fits, then overflow by a long char, then used up
    add_cfg(u2u8_pkg::REG_BYTE_BUDGET, 16'd4);
    add_unit(16'h00a0, 1'b1);
    add_typed(16'h0800, 1'b0, 1, done_beat(16'd2));
    add_unit(16'h0041, 1'b1);
    add_unit(16'h0041, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_typed(16'h0042, 1'b0, 1, done_beat(16'd4));
    // count only, same budget
    add_cfg(u2u8_pkg::REG_COUNT_ONLY, 16'h0001);
    add_unit(16'h0800, 1'b1);
    add_typed(16'h0080, 1'b0, 1, done_beat(16'd3));
    // zero budget: first unit ends the string
    add_cfg(u2u8_pkg::REG_BYTE_BUDGET, 16'h0000);
    add_typed(16'h0041, 1'b1, 1, done_beat(16'd0));
    add_cfg(u2u8_pkg::REG_BYTE_BUDGET, 16'hffff);
    add_cfg(u2u8_pkg::REG_COUNT_ONLY, 16'h0000);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < directed_rows.size(); r++) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_reg(directed_rows[r].reg_index, directed_rows[r].value);
      else
        send_unit(directed_rows[r].value, directed_rows[r].sos, directed_rows[r].typed,
                  directed_rows[r].n_typed, directed_rows[r].typed_beat, n);
    end

    // Random phases, each under its own register setting. The first string of a
    // phase may carry on without sos, so a budget change lands mid-string.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin budget = 16'hffff; co = 1'b0; end
        1:       begin budget = 16'd7;    co = 1'b0; end
        2:       begin budget = 16'd1;    co = 1'b1; end
        3:       begin budget = 16'd3;    co = 1'b0; end
        4:       begin budget = 16'd0;    co = 1'b0; end
        5:       begin budget = 16'($urandom); co = 1'($urandom_range(0, 1)); end
        6:       begin budget = 16'd2;    co = 1'b1; end
        7:       begin budget = 16'hffff; co = 1'b1; end
        8:       begin budget = 16'($urandom_range(4, 40)); co = 1'b0; end
        default: begin budget = 16'hffff; co = 1'b0; end
      endcase
      if (ph == PHASES - 1) quiet_tail = 1'b1;
      junk = $urandom;
      write_reg(u2u8_pkg::REG_BYTE_BUDGET, budget);
      // upper data bits are don't-care
      write_reg(u2u8_pkg::REG_COUNT_ONLY, {junk[15:1], co});
      counted = 0;
      send_string(1'($urandom_range(0, 1)), counted);
      while (counted < UNITS_PER_PH) send_string(1'b1, counted);
    end

    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, one long hold-off, none in the tail
  // ---------------------------------------------------------------------------
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_armed) begin
        long_hold_armed = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  task automatic note_failure(input string what, input beat_t want, input beat_t got);
    if (fail_count < 10) begin
      $write("%0t %s: exp byte=%02h bv=%0b last=%0b done=%0b total=%0d",
             $realtime, what, want.out_byte, want.byte_valid, want.last_flag,
             want.done_res, want.total_written);
      $display(" | got byte=%02h bv=%0b last=%0b done=%0b total=%0d",
               got.out_byte, got.byte_valid, got.last_flag, got.done_res,
               got.total_written);
    end
    fail_count++;
  endtask

  // Result checker: each output beat against the oldest expectation
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[7:0], m_tuser[0], m_tlast, m_tuser[1], m_tdata[23:8]};
      if (pending_beats.size() == 0) begin
        note_failure("unexpected beat", '0, got);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) note_failure("beat mismatch", want, got);
      end
    end
  end

  // Watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d beats still expected", pending_beats.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+design
design/u2u8_pkg.sv
design/u2u8_encode.sv
design/u2u8_serial.sv
design/utf16_unit_to_utf8_encoder_unit.sv
dv/tb_utf16_unit_to_utf8_encoder_unit.sv
